@@ rtl/core/chromaticity_reference_matcher_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chromaticity reference matcher
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CHROMATICITY_REFERENCE_MATCHER_UNIT_ASSERT_SVH
`define CHROMATICITY_REFERENCE_MATCHER_UNIT_ASSERT_SVH

`define CRM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CRM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/crm_pkg.sv @@
// ----------------------------------------------------------------------------
// Chromaticity reference matcher package
// Shared widths, operation and status codes, and the boot reference table.
// ----------------------------------------------------------------------------
`default_nettype none

package crm_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SHARE_W = 16;
    localparam int RAW_W   = 16;
    localparam int SUM_W   = RAW_W + 2;
    localparam int ACC_W   = 2 * SHARE_W + 2;
    localparam int BOOT_N  = 5;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_CMP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_NO_MATCH  = 2'd3;

    localparam logic [SHARE_W-1:0] TOL_RESET = 16'd3277;

    typedef struct packed {
        logic [SHARE_W-1:0] red;
        logic [SHARE_W-1:0] green;
        logic [SHARE_W-1:0] blue;
    } t_entry;

    function automatic t_entry boot_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        e = '0;
        case (idx)
            4'd0: e = '{16'd40305, 16'd13435, 16'd11665};
            4'd1: e = '{16'd38994, 16'd18416, 16'd8126};
            4'd2: e = '{16'd33292, 16'd22610, 16'd9634};
            4'd3: e = '{16'd39322, 16'd15729, 16'd10420};
            4'd4: e = '{16'd27656, 16'd21234, 16'd16646};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/crm_div.sv @@
// ----------------------------------------------------------------------------
// Share divider
// Restoring divider that forms a channel's Q0.16 share of the channel sum,
// one quotient bit per cycle, saturated at full scale and zero for a zero sum.
// ----------------------------------------------------------------------------
`default_nettype none

module crm_div
    import crm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [RAW_W-1:0]   i_num,
    input  wire logic [SUM_W-1:0]   i_den,
    output logic                    o_done,
    output logic [SHARE_W-1:0]      o_quot
);

    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_den;
    logic [SHARE_W-1:0] r_quot;
    logic [4:0]         r_cnt;
    logic               r_done;
    logic               r_sat;
    logic               r_zero;
    logic [SUM_W:0]     w_shift;
    logic               w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_rem  <= {2'b00, i_num};
                r_den  <= i_den;
                r_sat  <= ({2'b00, i_num} >= i_den);
                r_zero <= (i_den == '0);
                r_quot <= '0;
                r_cnt  <= 5'd16;
            end else if (r_cnt != '0) begin
                r_rem  <= w_ge ? SUM_W'(w_shift - {1'b0, r_den}) : w_shift[SUM_W-1:0];
                r_quot <= {r_quot[SHARE_W-2:0], w_ge};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : (r_sat ? '1 : r_quot);

endmodule

`default_nettype wire

@@ rtl/core/chromaticity_reference_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Chromaticity reference matcher
// Add, delete and compare requests on a packed table of Q0.16 color shares.
// Delete, full, invalid and unused requests end straight from idle; add and
// compare each make three 16-step passes of the shared divider.
// One request is in flight at a time; busy is high while add or compare runs.
// Results are strobed for one cycle on o_done; the receiver cannot stall.
// Synchronous active-low reset loads five boot references and tolerance 3277.
// ----------------------------------------------------------------------------
`default_nettype none

module chromaticity_reference_matcher_unit
    import crm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [RAW_W-1:0]   i_red_raw,
    input  wire logic [RAW_W-1:0]   i_green_raw,
    input  wire logic [RAW_W-1:0]   i_blue_raw,
    input  wire logic [IDX_W-1:0]   i_slot_index,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [CNT_W-1:0]        o_entry_count,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [SHARE_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         r_op;
    logic [IDX_W-1:0]   r_slot;
    logic [RAW_W-1:0]   r_red;
    logic [RAW_W-1:0]   r_green;
    logic [RAW_W-1:0]   r_blue;
    logic [SUM_W-1:0]   r_sum;
    logic [1:0]         r_ch;
    logic [2:0]         r_mi;
    logic [SHARE_W-1:0] r_sh [3];
    logic [2*SHARE_W-1:0] r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_count;
    logic [SHARE_W-1:0] r_tol;
    logic               r_div_go;
    logic               r_done;
    logic [1:0]         r_status;
    t_entry             r_tab [ENTRIES];

    logic               w_accept;
    logic               w_div_done;
    logic [SHARE_W-1:0] w_quot;
    logic [RAW_W-1:0]   w_num;
    logic               w_add_wr;
    logic               w_del;
    t_entry             w_ref;
    logic [SHARE_W-1:0] w_ref_ch;
    logic [SHARE_W-1:0] w_mine;
    logic [SHARE_W-1:0] w_diff;
    logic [SHARE_W-1:0] w_mul_a;

    assign w_accept = start && (r_state == S_IDLE);

    always_comb begin
        case (r_ch)
            2'd0:    w_num = r_red;
            2'd1:    w_num = r_green;
            default: w_num = r_blue;
        endcase
    end

    crm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (w_num),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_add_wr = (r_state == S_DIV) && w_div_done && (r_ch == 2'd2) && (r_op == OP_ADD);
    assign w_del    = w_accept && (i_opcode == OP_DEL) && ({1'b0, i_slot_index} < r_count);

    assign w_ref = r_tab[r_slot];
    always_comb begin
        case (r_mi)
            3'd0:    w_ref_ch = w_ref.red;
            3'd1:    w_ref_ch = w_ref.green;
            default: w_ref_ch = w_ref.blue;
        endcase
    end
    always_comb begin
        case (r_mi)
            3'd0:    w_mine = r_sh[0];
            3'd1:    w_mine = r_sh[1];
            default: w_mine = r_sh[2];
        endcase
    end
    assign w_diff  = (w_mine >= w_ref_ch) ? (w_mine - w_ref_ch) : (w_ref_ch - w_mine);
    assign w_mul_a = (r_mi < 3'd3) ? w_diff : r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_tab[i] <= boot_entry(IDX_W'(i));
            end
        end else if (w_del) begin
            for (int i = 0; i < ENTRIES - 1; i++) begin
                if (IDX_W'(i) >= i_slot_index) begin
                    r_tab[i] <= r_tab[i+1];
                end
            end
            r_tab[ENTRIES-1] <= '0;
        end else if (w_add_wr) begin
            r_tab[r_count[IDX_W-1:0]] <= '{r_sh[0], r_sh[1], w_quot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_div_go <= 1'b0;
            r_count  <= CNT_W'(BOOT_N);
            r_tol    <= TOL_RESET;
            r_status <= ST_OK;
        end else begin
            r_done   <= 1'b0;
            r_div_go <= 1'b0;
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_opcode;
                        r_slot  <= i_slot_index;
                        r_red   <= i_red_raw;
                        r_green <= i_green_raw;
                        r_blue  <= i_blue_raw;
                        r_sum   <= SUM_W'({2'b00, i_red_raw}) + SUM_W'({2'b00, i_green_raw})
                                 + SUM_W'({2'b00, i_blue_raw});
                        r_ch    <= 2'd0;
                        case (i_opcode)
                            OP_ADD: begin
                                if (r_count == CNT_W'(ENTRIES)) begin
                                    r_status <= ST_FULL;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state  <= S_DIV;
                                    r_div_go <= 1'b1;
                                end
                            end
                            OP_DEL: begin
                                if (w_del) begin
                                    r_count  <= r_count - CNT_W'(1);
                                    r_status <= ST_OK;
                                end else begin
                                    r_status <= ST_BAD_INDEX;
                                end
                                r_done <= 1'b1;
                            end
                            OP_CMP: begin
                                if ({1'b0, i_slot_index} < r_count) begin
                                    r_state  <= S_DIV;
                                    r_div_go <= 1'b1;
                                end else begin
                                    r_status <= ST_BAD_INDEX;
                                    r_done   <= 1'b1;
                                end
                            end
                            default: begin
                                r_status <= ST_BAD_INDEX;
                                r_done   <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_sh[r_ch] <= w_quot;
                        if (r_ch == 2'd2) begin
                            if (r_op == OP_ADD) begin
                                r_count  <= r_count + CNT_W'(1);
                                r_status <= ST_OK;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_MUL;
                                r_mi    <= 3'd0;
                                r_acc   <= '0;
                            end
                        end else begin
                            r_ch     <= r_ch + 2'd1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= w_mul_a * w_mul_a;
                    r_mi   <= r_mi + 3'd1;
                    if (r_mi >= 3'd1 && r_mi <= 3'd3) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    if (r_mi == 3'd4) begin
                        r_status <= (r_acc <= ACC_W'(r_prod)) ? ST_OK : ST_NO_MATCH;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

@@ rtl/core/crm_checker.sv @@
// ----------------------------------------------------------------------------
// Chromaticity reference matcher port checker
// Watches the top-level ports for request and result sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chromaticity_reference_matcher_unit_assert.svh"

module crm_checker
    import crm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               o_done,
    input  wire logic [1:0]         o_status,
    input  wire logic [CNT_W-1:0]   o_entry_count
);

    `CRM_ASSERT(a_count_range, i_clk, i_rst_n, o_entry_count <= CNT_W'(ENTRIES), "entry count above table size")
    `CRM_ASSERT(a_full_count, i_clk, i_rst_n, (o_done && o_status == ST_FULL) |-> (o_entry_count == CNT_W'(ENTRIES)), "full reported with free slots")
    `CRM_ASSERT_NEVER(a_done_busy, i_clk, i_rst_n, o_done && busy, "result shown while still busy")
    `CRM_ASSERT(a_busy_cause, i_clk, i_rst_n, $rose(busy) |-> $past(start), "busy rose without a request")

endmodule

bind chromaticity_reference_matcher_unit crm_checker u_crm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

@@ tb/chromaticity_reference_matcher_unit_test.sv @@
// ----------------------------------------------------------------------------
// Chromaticity reference matcher testbench
// Drives add, delete, compare and unused requests with random pacing, predicts
// the table and tolerance state in a scoreboard, and checks every status and
// entry count strobed on o_done. Several tolerance settings are exercised.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chromaticity_reference_matcher_unit_test;
    import crm_pkg::*;

    class color_table_scoreboard;
        logic [SHARE_W-1:0] red_share[ENTRIES];
        logic [SHARE_W-1:0] green_share[ENTRIES];
        logic [SHARE_W-1:0] blue_share[ENTRIES];
        bit                 occupied[ENTRIES];
        int unsigned        occupied_count;
        logic [SHARE_W-1:0] tolerance;
        logic [1:0]         status_q[$];
        logic [CNT_W-1:0]   count_q[$];
        int                 errors;
        int                 checked;
        int                 hits;
        int                 misses;
        int                 fulls;

        function new();
            t_entry e;
            for (int i = 0; i < ENTRIES; i++) begin
                e = boot_entry(IDX_W'(i));
                red_share[i] = e.red;
                green_share[i] = e.green;
                blue_share[i] = e.blue;
                occupied[i] = (i < BOOT_N);
            end
            occupied_count = BOOT_N;
            tolerance = TOL_RESET;
            errors = 0;
            checked = 0;
            hits = 0;
            misses = 0;
            fulls = 0;
        endfunction

        function logic [SHARE_W-1:0] share(input logic [31:0] ch, input logic [31:0] sum);
            logic [63:0] q;
            if (sum == 0) return '0;
            q = ({32'd0, ch} << 16) / sum;
            return (q > 64'd65535) ? 16'hFFFF : q[15:0];
        endfunction

        function logic [63:0] sqd(input logic [SHARE_W-1:0] a, input logic [SHARE_W-1:0] b);
            logic [63:0] d;
            d = (a >= b) ? 64'(a - b) : 64'(b - a);
            return d * d;
        endfunction

        function void note_request(input logic [1:0] op, input logic [RAW_W-1:0] r,
                                   input logic [RAW_W-1:0] g, input logic [RAW_W-1:0] b,
                                   input logic [IDX_W-1:0] slot);
            logic [1:0]  st;
            logic [31:0] sum;
            logic [SHARE_W-1:0] nr, ng, nb;
            logic [63:0] distance;
            int          k;
            st = ST_BAD_INDEX;
            sum = 32'(r) + 32'(g) + 32'(b);
            nr = share(32'(r), sum);
            ng = share(32'(g), sum);
            nb = share(32'(b), sum);
            if (op == OP_ADD) begin
                st = ST_FULL;
                k = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (k < 0 && !occupied[i]) k = i;
                end
                if (k >= 0) begin
                    red_share[k] = nr;
                    green_share[k] = ng;
                    blue_share[k] = nb;
                    occupied[k] = 1;
                    occupied_count++;
                    st = ST_OK;
                end else begin
                    fulls++;
                end
            end else if (op == OP_DEL) begin
                if (slot < occupied_count) begin
                    for (int i = slot; i + 1 < occupied_count; i++) begin
                        red_share[i] = red_share[i + 1];
                        green_share[i] = green_share[i + 1];
                        blue_share[i] = blue_share[i + 1];
                        occupied[i] = occupied[i + 1];
                    end
                    k = occupied_count - 1;
                    red_share[k] = '0;
                    green_share[k] = '0;
                    blue_share[k] = '0;
                    occupied[k] = 0;
                    occupied_count--;
                    st = ST_OK;
                end
            end else if (op == OP_CMP) begin
                if (occupied[slot]) begin
                    distance = sqd(nr, red_share[slot]) + sqd(ng, green_share[slot])
                             + sqd(nb, blue_share[slot]);
                    st = (distance <= 64'(tolerance) * 64'(tolerance)) ? ST_OK : ST_NO_MATCH;
                    if (st == ST_OK) hits++;
                    else misses++;
                end
            end
            status_q.push_back(st);
            count_q.push_back(occupied_count[CNT_W-1:0]);
        endfunction

        function void check_result(input logic [1:0] st, input logic [CNT_W-1:0] cnt);
            logic [1:0]       exp_st;
            logic [CNT_W-1:0] exp_cnt;
            if (status_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d count=%0d", $time, st, cnt);
                errors++;
                return;
            end
            exp_st = status_q.pop_front();
            exp_cnt = count_q.pop_front();
            checked++;
            if (st !== exp_st) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_st, st);
                errors++;
            end
            if (cnt !== exp_cnt) begin
                $display("%0t: entry count expected %0d actual %0d", $time, exp_cnt, cnt);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic [RAW_W-1:0]   i_red_raw;
    logic [RAW_W-1:0]   i_green_raw;
    logic [RAW_W-1:0]   i_blue_raw;
    logic [IDX_W-1:0]   i_slot_index;
    logic               o_done;
    logic [1:0]         o_status;
    logic [CNT_W-1:0]   o_entry_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [SHARE_W-1:0] i_cfg_data;

    color_table_scoreboard table_sb;

    chromaticity_reference_matcher_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_red_raw     (i_red_raw),
        .i_green_raw   (i_green_raw),
        .i_blue_raw    (i_blue_raw),
        .i_slot_index  (i_slot_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            table_sb.check_result(o_status, o_entry_count);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [RAW_W-1:0] r,
                                input logic [RAW_W-1:0] g, input logic [RAW_W-1:0] b,
                                input logic [IDX_W-1:0] slot, input bit paced);
        int gap;
        gap = paced ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_red_raw <= r;
        i_green_raw <= g;
        i_blue_raw <= b;
        i_slot_index <= slot;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        table_sb.note_request(op, r, g, b, slot);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (table_sb.status_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [SHARE_W-1:0] tol);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= tol;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        table_sb.tolerance = tol;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request(input bit paced);
        int          pick;
        logic [RAW_W-1:0] r, g, b;
        logic [IDX_W-1:0] slot;
        pick = $urandom_range(0, 99);
        r = RAW_W'($urandom);
        g = RAW_W'($urandom);
        b = RAW_W'($urandom);
        if ($urandom_range(0, 3) == 0) r = r >> $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) g = g >> $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) b = b >> $urandom_range(0, 15);
        slot = (table_sb.occupied_count > 0 && $urandom_range(0, 3) != 0)
             ? IDX_W'($urandom_range(0, table_sb.occupied_count - 1)) : IDX_W'($urandom);
        if (pick < 30) begin
            send_request(OP_ADD, r, g, b, slot, paced);
        end else if (pick < 55) begin
            send_request(OP_DEL, r, g, b, slot, paced);
        end else if (pick < 97) begin
            if (pick < 80 && table_sb.occupied[slot]) begin
                r = RAW_W'(table_sb.red_share[slot] + $urandom_range(0, 3000) - 1500);
                g = RAW_W'(table_sb.green_share[slot] + $urandom_range(0, 3000) - 1500);
                b = RAW_W'(table_sb.blue_share[slot] + $urandom_range(0, 3000) - 1500);
            end
            send_request(OP_CMP, r, g, b, slot, paced);
        end else begin
            send_request(2'd3, r, g, b, slot, paced);
        end
    endtask

    initial begin
        #20_000_000;
        $display("chromaticity_reference_matcher_unit_test: done, errors");
        $finish;
    end

    initial begin
        table_sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_ADD;
        i_red_raw = '0;
        i_green_raw = '0;
        i_blue_raw = '0;
        i_slot_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < BOOT_N; i++) begin
            send_request(OP_CMP, 16'd40305, 16'd13435, 16'd11665, IDX_W'(i), 1);
        end
        send_request(OP_CMP, 16'd0, 16'd0, 16'd0, 4'd0, 1);
        send_request(OP_CMP, 16'd100, 16'd100, 16'd100, 4'd15, 1);
        send_request(OP_DEL, 16'd0, 16'd0, 16'd0, 4'd15, 1);
        send_request(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1);
        send_request(OP_ADD, 16'hFFFF, 16'd0, 16'd0, 4'd0, 1);
        send_request(OP_ADD, 16'd0, 16'd0, 16'd0, 4'd0, 1);
        send_request(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 1);
        for (int i = 0; i < 9; i++) send_request(OP_ADD, 16'd1, 16'd2, 16'd3, 4'd0, 0);
        send_request(OP_ADD, 16'd5, 16'd5, 16'd5, 4'd0, 0);
        send_request(OP_CMP, 16'hFFFF, 16'd0, 16'd0, 4'd5, 1);
        send_request(OP_DEL, 16'd0, 16'd0, 16'd0, 4'd15, 1);
        send_request(OP_DEL, 16'd0, 16'd0, 16'd0, 4'd0, 1);
        send_request(OP_CMP, 16'd1, 16'd2, 16'd3, 4'd15, 1);

        write_tolerance(16'd0);
        send_request(OP_CMP, 16'd0, 16'hFFFF, 16'd0, 4'd3, 1);
        for (int i = 0; i < 400; i++) random_request(i % 100 > 20);
        write_tolerance(16'hFFFF);
        for (int i = 0; i < 400; i++) random_request(i % 100 > 20);
        write_tolerance(16'd1000);
        for (int i = 0; i < 500; i++) random_request(i % 100 > 20);
        write_tolerance(TOL_RESET);
        for (int i = 0; i < 475; i++) random_request(i % 100 > 20);
        drain();

        $display("Covered %0d results: %0d matches, %0d misses, %0d full adds,",
                 table_sb.checked, table_sb.hits, table_sb.misses, table_sb.fulls);
        $display("over four tolerance settings including zero and full scale.");
        if (table_sb.errors == 0 && table_sb.status_q.size() == 0) begin
            $display("chromaticity_reference_matcher_unit_test: done, clean");
        end else begin
            $display("chromaticity_reference_matcher_unit_test: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/crm_pkg.sv
rtl/core/crm_div.sv
rtl/core/chromaticity_reference_matcher_unit.sv
rtl/core/crm_checker.sv
tb/chromaticity_reference_matcher_unit_test.sv
